### rtl/ccns_pkg.sv
package ccns_pkg;

    // The crop origin sits at half of the leftover width or height.
    localparam int CROP_HALF = 2;

    localparam int CFG_REG_WIDTH = 13;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;

    localparam logic [CFG_REG_WIDTH-1:0] RST_SOURCE_WIDTH  = 13'd1280;
    localparam logic [CFG_REG_WIDTH-1:0] RST_SOURCE_HEIGHT = 13'd720;
    localparam logic [CFG_REG_WIDTH-1:0] RST_TARGET_WIDTH  = 13'd240;
    localparam logic [CFG_REG_WIDTH-1:0] RST_TARGET_HEIGHT = 13'd240;

    localparam int DEFAULT_MAX_DIM = 4096;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_SETUP,
        ST_DIVIDE,
        ST_RUN
    } t_state;

endpackage

### rtl/center_crop_nearest_scaler.sv
// Center-crop nearest-neighbor downscaler for an RGB565 raster stream.
//
// Input channel: i_valid / o_stall carry one source pixel per transaction in
// raster order. Output channel: o_valid / i_stall carry the selected pixels
// with row_end and frame_end marks. The centered square crop of side
// min(width, height) is resampled to target_width x target_height, each
// clamped to the crop side, so every source pixel yields zero or one result.
//
// Throughput is one source pixel per cycle; a selected pixel appears at the
// output register in the cycle after its transaction. The result register
// lets a new pixel enter while the previous result still waits; in ST_RUN a
// pixel is held off only while it is full and the receiver stalls.
//
// After reset and after every register write the frame restarts and a setup
// pass runs: ST_SETUP settles the crop geometry, then in ST_DIVIDE two
// restoring dividers find the column and row step quotients and remainders.
// o_stall is high throughout. Registers are written over the APB-style port
// at byte address 4*index.
module center_crop_nearest_scaler
    import ccns_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [15:0]               i_pixel_in,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [15:0]               o_pixel_out,
    output logic                      o_row_end,
    output logic                      o_frame_end,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = CW + 1;
    localparam int SW = $clog2(DW);

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_REG_WIDTH-1:0] v);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(v);
        end
        return res;
    endfunction

    // One restoring division step: returns {next quotient/dividend, next remainder}.
    function automatic logic [2*DW-1:0] div_step(input logic [DW-1:0] q,
                                                 input logic [DW-1:0] rem,
                                                 input logic [DW-1:0] d);
        logic [DW:0]   sh;
        logic [DW+1:0] diff;
        logic [2*DW-1:0] res;
        sh   = {rem, q[DW-1]};
        diff = {1'b0, sh} - {2'b00, d};
        if (diff[DW+1]) begin
            res = {q[DW-2:0], 1'b0, sh[DW-1:0]};
        end else begin
            res = {q[DW-2:0], 1'b1, diff[DW-1:0]};
        end
        return res;
    endfunction

    // Configuration registers
    logic [CFG_REG_WIDTH-1:0] r_source_width, r_source_height;
    logic [CFG_REG_WIDTH-1:0] r_target_width, r_target_height;

    // Geometry, settled in the setup cycle
    logic [DW-1:0] r_w, r_h, r_tw, r_th, r_cx, r_cy, r_row_stop;

    // Step dividers: quotient ends up in r_*q, remainder in r_*r
    logic [DW-1:0] r_cq, r_cr, r_rq, r_rr;
    logic [SW-1:0] r_div_cnt;

    // Position state
    logic [CW-1:0] r_in_col, r_in_row, r_out_col, r_out_row;
    logic [DW-1:0] r_wanted_col, r_wanted_row;
    logic [CW-1:0] r_col_rem, r_row_rem;

    // Result register
    logic          r_out_valid;
    logic [15:0]   r_pixel_out;
    logic          r_row_end, r_frame_end;

    t_state r_state, n_state;

    logic cfg_wr;
    logic accept;
    logic div_last;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign div_last = (r_div_cnt == '0);

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= RST_SOURCE_WIDTH;
            r_source_height <= RST_SOURCE_HEIGHT;
            r_target_width  <= RST_TARGET_WIDTH;
            r_target_height <= RST_TARGET_HEIGHT;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_SOURCE_WIDTH:  r_source_width  <= pwdata[CFG_REG_WIDTH-1:0];
                REG_SOURCE_HEIGHT: r_source_height <= pwdata[CFG_REG_WIDTH-1:0];
                REG_TARGET_WIDTH:  r_target_width  <= pwdata[CFG_REG_WIDTH-1:0];
                REG_TARGET_HEIGHT: r_target_height <= pwdata[CFG_REG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_SOURCE_WIDTH:  prdata = APB_DATA_WIDTH'(r_source_width);
            REG_SOURCE_HEIGHT: prdata = APB_DATA_WIDTH'(r_source_height);
            REG_TARGET_WIDTH:  prdata = APB_DATA_WIDTH'(r_target_width);
            REG_TARGET_HEIGHT: prdata = APB_DATA_WIDTH'(r_target_height);
            default:           prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SETUP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        case (r_state)
            ST_SETUP: begin
                n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_stall = r_out_valid && i_stall;
            end
            default: begin
                n_state = ST_SETUP;
            end
        endcase
        // Any register write restarts the frame under the new geometry.
        if (cfg_wr) begin
            n_state = ST_SETUP;
        end
    end

    assign accept = i_valid && !o_stall;

    // ---------------- geometry ----------------
    logic [DW-1:0] c_w, c_h, c_s, c_tw, c_th, c_cx, c_cy;

    always_comb begin
        c_w  = clamp_dim(r_source_width);
        c_h  = clamp_dim(r_source_height);
        c_s  = (c_w < c_h) ? c_w : c_h;
        c_cx = DW'((c_w - c_s) / CROP_HALF);
        c_cy = DW'((c_h - c_s) / CROP_HALF);
        c_tw = clamp_dim(r_target_width);
        c_th = clamp_dim(r_target_height);
        if (c_tw > c_s) begin
            c_tw = c_s;
        end
        if (c_th > c_s) begin
            c_th = c_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP) begin
            r_w        <= c_w;
            r_h        <= c_h;
            r_tw       <= c_tw;
            r_th       <= c_th;
            r_cx       <= c_cx;
            r_cy       <= c_cy;
            r_row_stop <= c_cy + c_s;
        end
    end

    // ---------------- step dividers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= SW'(DW - 1);
        end else if (r_state == ST_SETUP) begin
            r_div_cnt <= SW'(DW - 1);
        end else if (r_state == ST_DIVIDE && !div_last) begin
            r_div_cnt <= r_div_cnt - SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP) begin
            r_cq <= c_s;
            r_cr <= '0;
            r_rq <= c_s;
            r_rr <= '0;
        end else if (r_state == ST_DIVIDE) begin
            {r_cq, r_cr} <= div_step(r_cq, r_cr, r_tw);
            {r_rq, r_rr} <= div_step(r_rq, r_rr, r_th);
        end
    end

    // ---------------- per-pixel datapath ----------------
    logic          hit, last_col, last_row, col_wrap, row_wrap;
    logic          in_col_last, in_row_last;
    logic [DW-1:0] col_sum, row_sum;

    always_comb begin
        hit = ({1'b0, r_in_col} == r_wanted_col) &&
              ({1'b0, r_in_row} == r_wanted_row) &&
              (r_wanted_row < r_row_stop) &&
              ({1'b0, r_out_col} < r_tw) &&
              ({1'b0, r_out_row} < r_th);
        last_col    = ({1'b0, r_out_col} + DW'(1)) >= r_tw;
        last_row    = ({1'b0, r_out_row} + DW'(1)) >= r_th;
        col_sum     = {1'b0, r_col_rem} + DW'(r_cr);
        row_sum     = {1'b0, r_row_rem} + DW'(r_rr);
        col_wrap    = col_sum >= r_tw;
        row_wrap    = row_sum >= r_th;
        in_col_last = ({1'b0, r_in_col} + DW'(1)) >= r_w;
        in_row_last = ({1'b0, r_in_row} + DW'(1)) >= r_h;
    end

    logic [CW-1:0] n_in_col, n_in_row, n_out_col, n_out_row, n_col_rem, n_row_rem;
    logic [DW-1:0] n_wanted_col, n_wanted_row;

    always_comb begin
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_wanted_col = r_wanted_col;
        n_wanted_row = r_wanted_row;
        n_col_rem    = r_col_rem;
        n_row_rem    = r_row_rem;
        if (hit) begin
            if (!last_col) begin
                n_out_col    = r_out_col + CW'(1);
                n_wanted_col = r_wanted_col + r_cq + DW'(col_wrap);
                n_col_rem    = col_wrap ? CW'(col_sum - r_tw) : CW'(col_sum);
            end else begin
                n_out_col    = '0;
                n_wanted_col = r_cx;
                n_col_rem    = '0;
                if (!last_row) begin
                    n_out_row    = r_out_row + CW'(1);
                    n_wanted_row = r_wanted_row + r_rq + DW'(row_wrap);
                    n_row_rem    = row_wrap ? CW'(row_sum - r_th) : CW'(row_sum);
                end else begin
                    // Output frame done: park the row beyond the crop.
                    n_wanted_row = r_row_stop;
                    n_row_rem    = '0;
                end
            end
        end
        if (in_col_last) begin
            if (in_row_last) begin
                // Source frame wrap overrides everything above.
                n_in_col     = '0;
                n_in_row     = '0;
                n_out_col    = '0;
                n_out_row    = '0;
                n_wanted_col = r_cx;
                n_wanted_row = r_cy;
                n_col_rem    = '0;
                n_row_rem    = '0;
            end else begin
                n_in_col = '0;
                n_in_row = r_in_row + CW'(1);
            end
        end else begin
            n_in_col = r_in_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_wanted_col <= c_cx;
            r_wanted_row <= c_cy;
            r_col_rem    <= '0;
            r_row_rem    <= '0;
        end else if (accept) begin
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_wanted_col <= n_wanted_col;
            r_wanted_row <= n_wanted_row;
            r_col_rem    <= n_col_rem;
            r_row_rem    <= n_row_rem;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && hit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hit) begin
            r_pixel_out <= i_pixel_in;
            r_row_end   <= last_col;
            r_frame_end <= last_col && last_row;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

    // ---------------- assertions ----------------
    a_frame_end_on_row_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_frame_end || o_row_end)
    ) else $error("frame end without row end");

    a_write_restarts: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == ST_SETUP)
    ) else $error("register write did not restart the frame");

    a_remainders_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (({1'b0, r_col_rem} < r_tw) && ({1'b0, r_row_rem} < r_th))
    ) else $error("step remainder out of range");

    a_no_result_from_setup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN && !o_valid) |=> !o_valid
    ) else $error("result produced during setup");

endmodule
